// File: hdl/fragment_reassembly_table_macros.svh
// Assertion helpers used by the reassembly table top level.
`ifndef FRAGMENT_REASSEMBLY_TABLE_MACROS_SVH
`define FRAGMENT_REASSEMBLY_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define FRT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("reassembly table invariant violated");

// Next-cycle implication, disabled while reset is high.
`define FRT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("reassembly table sequencing violated");

`endif

// File: hdl/frt_pkg.sv
// ----------------------------------------------------------------------------
// frt_pkg
// Shared sizes, codes and types of the fragment reassembly table.
// ----------------------------------------------------------------------------
package frt_pkg;

   localparam int SLOT_COUNT   = 4;
   localparam int SLOT_W       = $clog2(SLOT_COUNT);
   localparam int CELL_BYTES   = 1088;
   localparam int HEADER_BYTES = 12;
   localparam int MAX_FRAMES   = 8;
   localparam int STORE_DEPTH  = SLOT_COUNT * CELL_BYTES;
   localparam int ADDR_W       = $clog2(STORE_DEPTH);
   localparam int POS_W        = $clog2(CELL_BYTES + 1);
   localparam int REQ_TDATA_W  = 208;
   localparam int RSP_TDATA_W  = 144;

   typedef enum logic [1:0] {
      ACT_HEADER  = 2'd0,
      ACT_PAYLOAD = 2'd1,
      ACT_READ    = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STAT_BAD        = 2'd0,
      STAT_INCOMPLETE = 2'd1,
      STAT_COMPLETE   = 2'd2,
      STAT_READ       = 2'd3
   } status_type;

   typedef enum logic [0:0] {
      CSR_FRAME_MAGIC = 1'b0,
      CSR_SLOT_TTL    = 1'b1
   } csr_index_type;

   typedef enum logic [8:0] {
      S_INIT   = 9'b000000001,
      S_IDLE   = 9'b000000010,
      S_DECODE = 9'b000000100,
      S_SCAN   = 9'b000001000,
      S_CLEAR  = 9'b000010000,
      S_CHECK  = 9'b000100000,
      S_FINISH = 9'b001000000,
      S_RDWAIT = 9'b010000000,
      S_EMIT   = 9'b100000000
   } state_type;

   typedef struct packed {
      logic [15:0] frame_magic;
      logic [31:0] slot_ttl_ms;
   } cfg_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [7:0]        wr_data;
      logic [ADDR_W-1:0] rd_addr;
   } ram_req_type;

   typedef struct packed {
      logic init_busy;
      logic in_frame;
   } ctrl_status_type;

   // First byte address of a slot's buffer in the cell store.
   function automatic logic [ADDR_W-1:0] base_addr(input logic [SLOT_W-1:0] slot);
      return ADDR_W'(slot) * ADDR_W'(CELL_BYTES);
   endfunction

endpackage

// File: hdl/frt_ram.sv
// ----------------------------------------------------------------------------
// frt_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module frt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/frt_ctrl.sv
// ----------------------------------------------------------------------------
// frt_ctrl
// Sequencer of the reassembly table: header checks, slot scan, buffer
// clearing, payload stores, read-back and the result register.
// ----------------------------------------------------------------------------
module frt_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  frt_pkg::cfg_type                    cfg,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [1:0]                          req_tuser,
   input  logic [frt_pkg::REQ_TDATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [1:0]                          rsp_tuser,
   output logic [frt_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output frt_pkg::ram_req_type                ram_req,
   input  logic [7:0]                          ram_rd_data,
   output frt_pkg::ctrl_status_type            status
);
   import frt_pkg::*;

   state_type state_ff, state_in;

   // Captured request word.
   action_type  act_ff, act_in;
   logic [7:0]  flen_ff, flen_in;
   logic [15:0] magic_ff, magic_in;
   logic [7:0]  seq_ff, seq_in;
   logic [7:0]  cnt_ff, cnt_in;
   logic [31:0] cell_ff, cell_in;
   logic [15:0] off_ff, off_in;
   logic [47:0] mac_ff, mac_in;
   logic [47:0] now_ff, now_in;
   logic [7:0]  byte_ff, byte_in;
   logic [1:0]  rslot_ff, rslot_in;
   logic [10:0] rindex_ff, rindex_in;

   // Frame in progress.
   logic              active_ff, active_in;
   logic [SLOT_W-1:0] ctx_slot_ff, ctx_slot_in;
   logic [POS_W-1:0]  ctx_pos_ff, ctx_pos_in;
   logic [7:0]        ctx_left_ff, ctx_left_in;
   logic [2:0]        ctx_seq_ff, ctx_seq_in;
   logic [3:0]        ctx_count_ff, ctx_count_in;

   // Slot scan bookkeeping.
   logic [SLOT_W-1:0] scan_ff, scan_in;
   logic              free_found_ff, free_found_in;
   logic [SLOT_W-1:0] free_idx_ff, free_idx_in;
   logic              old_found_ff, old_found_in;
   logic [SLOT_W-1:0] old_idx_ff, old_idx_in;
   logic [47:0]       old_age_ff, old_age_in;
   logic [SLOT_W-1:0] pick_ff, pick_in;
   logic [POS_W-1:0]  clr_ff, clr_in;
   logic [ADDR_W-1:0] init_ff, init_in;
   logic              oor_ff, oor_in;

   // Slot table.
   logic        busy_ff   [SLOT_COUNT];
   logic        busy_in   [SLOT_COUNT];
   logic [47:0] sender_ff [SLOT_COUNT];
   logic [47:0] sender_in [SLOT_COUNT];
   logic [31:0] scell_ff  [SLOT_COUNT];
   logic [31:0] scell_in  [SLOT_COUNT];
   logic [3:0]  expect_ff [SLOT_COUNT];
   logic [3:0]  expect_in [SLOT_COUNT];
   logic [7:0]  seen_ff   [SLOT_COUNT];
   logic [7:0]  seen_in   [SLOT_COUNT];
   logic [47:0] start_ff  [SLOT_COUNT];
   logic [47:0] start_in  [SLOT_COUNT];

   // Statistics and the pending result.
   logic [31:0] pushed_ff, pushed_in;
   logic [31:0] dropped_ff, dropped_in;
   logic [31:0] bad_ff, bad_in;
   logic [31:0] reasm_ff, reasm_in;
   status_type  res_status_ff, res_status_in;
   logic [1:0]  res_slot_ff, res_slot_in;
   logic [7:0]  res_byte_ff, res_byte_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_user_ff, rsp_user_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Header validation of the captured word.
   logic [7:0] plen;
   logic       hdr_bad;
   logic       hdr_overrun;

   assign plen        = flen_ff - 8'(HEADER_BYTES);
   assign hdr_bad     = (flen_ff < 8'(HEADER_BYTES)) || (magic_ff != cfg.frame_magic) ||
                        (cnt_ff == 8'd0) || (cnt_ff > 8'(MAX_FRAMES)) || (seq_ff >= cnt_ff);
   assign hdr_overrun = (17'(off_ff) + 17'(plen)) > 17'(CELL_BYTES);

   // Age test of the slot under the scan pointer.
   logic [47:0] diff;
   logic        later;
   logic        expired;
   logic        busy_eff;
   logic        hit;
   logic [47:0] age;

   assign diff     = now_ff - start_ff[scan_ff];
   assign later    = now_ff > start_ff[scan_ff];
   assign expired  = busy_ff[scan_ff] && later && (diff > {16'd0, cfg.slot_ttl_ms});
   assign busy_eff = busy_ff[scan_ff] && !expired;
   assign hit      = busy_eff && (sender_ff[scan_ff] == mac_ff) && (scell_ff[scan_ff] == cell_ff);
   assign age      = later ? diff : 48'd0;

   assign req_tready = (state_ff == S_IDLE);

   // Next-state logic of the whole sequencer.
   always_comb begin
      logic              free_now;
      logic [SLOT_W-1:0] free_idx_now;
      logic              old_found_now;
      logic [SLOT_W-1:0] old_idx_now;
      logic [SLOT_W-1:0] pick;
      logic [7:0]        want;
      logic [7:0]        mask;

      state_in      = state_ff;
      act_in        = act_ff;
      flen_in       = flen_ff;
      magic_in      = magic_ff;
      seq_in        = seq_ff;
      cnt_in        = cnt_ff;
      cell_in       = cell_ff;
      off_in        = off_ff;
      mac_in        = mac_ff;
      now_in        = now_ff;
      byte_in       = byte_ff;
      rslot_in      = rslot_ff;
      rindex_in     = rindex_ff;
      active_in     = active_ff;
      ctx_slot_in   = ctx_slot_ff;
      ctx_pos_in    = ctx_pos_ff;
      ctx_left_in   = ctx_left_ff;
      ctx_seq_in    = ctx_seq_ff;
      ctx_count_in  = ctx_count_ff;
      scan_in       = scan_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      old_found_in  = old_found_ff;
      old_idx_in    = old_idx_ff;
      old_age_in    = old_age_ff;
      pick_in       = pick_ff;
      clr_in        = clr_ff;
      init_in       = init_ff;
      oor_in        = oor_ff;
      busy_in       = busy_ff;
      sender_in     = sender_ff;
      scell_in      = scell_ff;
      expect_in     = expect_ff;
      seen_in       = seen_ff;
      start_in      = start_ff;
      pushed_in     = pushed_ff;
      dropped_in    = dropped_ff;
      bad_in        = bad_ff;
      reasm_in      = reasm_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_byte_in   = res_byte_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_user_in   = rsp_user_ff;
      rsp_data_in   = rsp_data_ff;
      ram_req       = '0;
      free_now      = free_found_ff;
      free_idx_now  = free_idx_ff;
      old_found_now = old_found_ff;
      old_idx_now   = old_idx_ff;
      pick          = '0;
      want          = 8'((9'd1 << ctx_count_ff) - 9'd1);
      mask          = seen_ff[ctx_slot_ff] | (8'd1 << ctx_seq_ff);

      // The result register empties when its word is taken.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_INIT: begin
            // Zero the whole cell store after reset.
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = init_ff;
            init_in         = init_ff + 1'b1;
            if (init_ff == ADDR_W'(STORE_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               act_in    = action_type'(req_tuser);
               flen_in   = req_tdata[7:0];
               magic_in  = req_tdata[23:8];
               seq_in    = req_tdata[31:24];
               cnt_in    = req_tdata[39:32];
               cell_in   = req_tdata[71:40];
               off_in    = req_tdata[87:72];
               mac_in    = req_tdata[135:88];
               now_in    = req_tdata[183:136];
               byte_in   = req_tdata[191:184];
               rslot_in  = req_tdata[193:192];
               rindex_in = req_tdata[204:194];
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            case (act_ff)
               ACT_HEADER: begin
                  active_in = 1'b0;
                  if (hdr_bad || hdr_overrun) begin
                     bad_in        = bad_ff + 32'd1;
                     res_status_in = STAT_BAD;
                     res_slot_in   = 2'd0;
                     res_byte_in   = 8'd0;
                     state_in      = S_EMIT;
                  end else begin
                     pushed_in     = pushed_ff + 32'd1;
                     scan_in       = '0;
                     free_found_in = 1'b0;
                     old_found_in  = 1'b0;
                     old_age_in    = 48'd0;
                     state_in      = S_SCAN;
                  end
               end
               ACT_PAYLOAD: begin
                  if (active_ff) begin
                     if (ctx_pos_ff < POS_W'(CELL_BYTES)) begin
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_addr = base_addr(ctx_slot_ff) + ADDR_W'(ctx_pos_ff);
                        ram_req.wr_data = byte_ff;
                     end
                     ctx_pos_in  = ctx_pos_ff + 1'b1;
                     ctx_left_in = ctx_left_ff - 8'd1;
                     state_in    = (ctx_left_ff == 8'd1) ? S_FINISH : S_IDLE;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
               ACT_READ: begin
                  oor_in = (32'(rslot_ff) >= 32'(SLOT_COUNT)) ||
                           (32'(rindex_ff) >= 32'(CELL_BYTES));
                  ram_req.rd_addr = base_addr(SLOT_W'(rslot_ff)) + ADDR_W'(rindex_ff);
                  state_in = S_RDWAIT;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_SCAN: begin
            // One slot a cycle: TTL eviction, then key match, free and oldest tracking.
            if (expired) begin
               busy_in[scan_ff] = 1'b0;
               dropped_in       = dropped_ff + 32'd1;
            end
            if (hit) begin
               pick_in  = scan_ff;
               state_in = S_CHECK;
            end else begin
               if (!busy_eff && !free_found_ff) begin
                  free_now     = 1'b1;
                  free_idx_now = scan_ff;
               end
               if (busy_eff && (!old_found_ff || (age > old_age_ff))) begin
                  old_found_now = 1'b1;
                  old_idx_now   = scan_ff;
                  old_age_in    = age;
               end
               free_found_in = free_now;
               free_idx_in   = free_idx_now;
               old_found_in  = old_found_now;
               old_idx_in    = old_idx_now;
               if (scan_ff == SLOT_W'(SLOT_COUNT - 1)) begin
                  if (free_now) begin
                     pick = free_idx_now;
                  end else begin
                     pick       = old_found_now ? old_idx_now : '0;
                     dropped_in = dropped_in + 32'd1;
                  end
                  sender_in[pick] = mac_ff;
                  scell_in[pick]  = cell_ff;
                  expect_in[pick] = 4'd0;
                  seen_in[pick]   = 8'd0;
                  start_in[pick]  = now_ff;
                  busy_in[pick]   = 1'b1;
                  pick_in         = pick;
                  clr_in          = '0;
                  state_in        = S_CLEAR;
               end else begin
                  scan_in = scan_ff + 1'b1;
               end
            end
         end
         S_CLEAR: begin
            // Zero the new slot's buffer, one byte a cycle.
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = base_addr(pick_ff) + ADDR_W'(clr_ff);
            clr_in          = clr_ff + 1'b1;
            if (clr_ff == POS_W'(CELL_BYTES - 1)) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            // Frame count must agree with what the slot already holds.
            if ((expect_ff[pick_ff] != 4'd0) && (expect_ff[pick_ff] != cnt_ff[3:0])) begin
               busy_in[pick_ff] = 1'b0;
               bad_in           = bad_ff + 32'd1;
               res_status_in    = STAT_BAD;
               res_slot_in      = 2'd0;
               res_byte_in      = 8'd0;
               state_in         = S_EMIT;
            end else begin
               if (expect_ff[pick_ff] == 4'd0) begin
                  expect_in[pick_ff] = cnt_ff[3:0];
               end
               active_in    = 1'b1;
               ctx_slot_in  = pick_ff;
               ctx_pos_in   = POS_W'(off_ff);
               ctx_left_in  = plen;
               ctx_seq_in   = seq_ff[2:0];
               ctx_count_in = cnt_ff[3:0];
               state_in     = (plen == 8'd0) ? S_FINISH : S_IDLE;
            end
         end
         S_FINISH: begin
            // Mark the frame seen and test the mask for a whole cell.
            active_in            = 1'b0;
            seen_in[ctx_slot_ff] = mask;
            res_slot_in          = 2'(ctx_slot_ff);
            res_byte_in          = 8'd0;
            if ((mask & want) == want) begin
               busy_in[ctx_slot_ff] = 1'b0;
               reasm_in             = reasm_ff + 32'd1;
               res_status_in        = STAT_COMPLETE;
            end else begin
               res_status_in = STAT_INCOMPLETE;
            end
            state_in = S_EMIT;
         end
         S_RDWAIT: begin
            res_status_in = STAT_READ;
            res_slot_in   = rslot_ff;
            res_byte_in   = oor_ff ? 8'd0 : ram_rd_data;
            state_in      = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = res_status_ff;
               rsp_data_in  = {6'd0, reasm_ff, bad_ff, dropped_ff, pushed_ff,
                               res_byte_ff, res_slot_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state with synchronous reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         init_ff      <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pushed_ff    <= 32'd0;
         dropped_ff   <= 32'd0;
         bad_ff       <= 32'd0;
         reasm_ff     <= 32'd0;
         busy_ff      <= '{default: 1'b0};
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         pushed_ff    <= pushed_in;
         dropped_ff   <= dropped_in;
         bad_ff       <= bad_in;
         reasm_ff     <= reasm_in;
         busy_ff      <= busy_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      flen_ff       <= flen_in;
      magic_ff      <= magic_in;
      seq_ff        <= seq_in;
      cnt_ff        <= cnt_in;
      cell_ff       <= cell_in;
      off_ff        <= off_in;
      mac_ff        <= mac_in;
      now_ff        <= now_in;
      byte_ff       <= byte_in;
      rslot_ff      <= rslot_in;
      rindex_ff     <= rindex_in;
      ctx_slot_ff   <= ctx_slot_in;
      ctx_pos_ff    <= ctx_pos_in;
      ctx_left_ff   <= ctx_left_in;
      ctx_seq_ff    <= ctx_seq_in;
      ctx_count_ff  <= ctx_count_in;
      scan_ff       <= scan_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      old_found_ff  <= old_found_in;
      old_idx_ff    <= old_idx_in;
      old_age_ff    <= old_age_in;
      pick_ff       <= pick_in;
      clr_ff        <= clr_in;
      oor_ff        <= oor_in;
      sender_ff     <= sender_in;
      scell_ff      <= scell_in;
      expect_ff     <= expect_in;
      seen_ff       <= seen_in;
      start_ff      <= start_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_byte_ff   <= res_byte_in;
      rsp_user_ff   <= rsp_user_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_tuser        = rsp_user_ff;
   assign rsp_tdata        = rsp_data_ff;
   assign status.init_busy = (state_ff == S_INIT);
   assign status.in_frame  = active_ff;

endmodule

// File: hdl/fragment_reassembly_table.sv
// ----------------------------------------------------------------------------
// fragment_reassembly_table
// Reassembles cells from header and payload-byte words into four slot
// buffers, with TTL eviction, statistics and byte read-back.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake              Contents
//  req_     in         req_tvalid/req_tready  tuser action, tdata header/byte/read
//  rsp_     out        rsp_tvalid/rsp_tready  tuser status, tdata slot/byte/counters
//  csr_     in         csr_valid/csr_ready    csr_index, csr_data
//
// An idle word, a stray payload word or a payload word that is not the last of
// its frame passes through DECODE back to IDLE; a frame's last payload word then
// passes FINISH and EMIT, a read word RDWAIT and EMIT, and a rejected header
// EMIT alone. An accepted header scans the slots one a cycle and, when it
// allocates a slot, zeroes that slot's 1088-byte buffer through the RAM write
// port. After reset the whole 4352-byte store is zeroed, with req_tready low.
// A stalled result holds in the output register while the next word is taken;
// no further result is loaded until it is gone.
//
`include "fragment_reassembly_table_macros.svh"

module fragment_reassembly_table (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // action[1:0]
   input  logic [1:0]                        req_tuser,
   // flen[7:0] magic[23:8] seq[31:24] count[39:32]
   // cell_id[71:40] offset[87:72] src_mac[135:88] now_ms[183:136]
   // data_byte[191:184] read_slot[193:192] read_index[204:194], zero above
   input  logic [frt_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // status[1:0]
   output logic [1:0]                        rsp_tuser,
   // slot_index[1:0] read_byte[9:2] pushed_count[41:10] dropped_count[73:42]
   // bad_count[105:74] reassembled_count[137:106], zero above
   output logic [frt_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [0:0]                        csr_index,
   input  logic [31:0]                       csr_data
);
   import frt_pkg::*;

   logic [15:0] magic_ff, magic_in;
   logic [31:0] ttl_ff, ttl_in;

   cfg_type         cfg;
   ram_req_type     ram_req;
   logic [7:0]      ram_rd_data;
   ctrl_status_type status;

   // Configuration registers.
   always_comb begin
      magic_in = magic_ff;
      ttl_in   = ttl_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_FRAME_MAGIC: magic_in = csr_data[15:0];
            CSR_SLOT_TTL:    ttl_in   = csr_data;
            default:         magic_in = magic_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff <= 16'd0;
         ttl_ff   <= 32'd5000;
      end else begin
         magic_ff <= magic_in;
         ttl_ff   <= ttl_in;
      end
   end

   assign csr_ready       = 1'b1;
   assign cfg.frame_magic = magic_ff;
   assign cfg.slot_ttl_ms = ttl_ff;

   // Cell store.
   frt_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_rd_data)
   );

   // Sequencer.
   frt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata),
      .ram_req     (ram_req),
      .ram_rd_data (ram_rd_data),
      .status      (status)
   );

   // Checks.
   `FRT_ASSERT_NXT(a_one_word_in_flight, clock, reset, req_tvalid && req_tready, !req_tready)
   `FRT_ASSERT_IMP(a_no_input_during_init, clock, reset, status.init_busy, !req_tready)
   `FRT_ASSERT_IMP(a_bad_result_clean, clock, reset, rsp_tvalid && (rsp_tuser == STAT_BAD), rsp_tdata[9:0] == 10'd0)

endmodule
